@@ src/gh_pkg.sv @@
package gh_pkg;

    // Coordinate geometry: inputs are 54-bit signed, valid span is +/- 2^52
    localparam int GH_COORD_W = 54;
    localparam int GH_OFS_W   = 53;
    localparam int GH_SUM_W   = 55;

    // Bias of 2^52 - 1 turns a coordinate into (offset - 1); its binary
    // expansion is exactly the sequence of bisection decisions.
    localparam logic signed [GH_SUM_W-1:0] GH_BIAS = 55'sd4503599627370495;
    localparam logic signed [GH_SUM_W-1:0] GH_SPAN = 55'sd9007199254740991;

    localparam logic [4:0] GH_FALLBACK_CHARS = 5'd12;

    // Base-32 alphabet, first character in the top byte
    localparam logic [255:0] GH_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    // Offsets of both coordinates plus the range flag, handed to the cells
    typedef struct packed {
        logic [GH_OFS_W-1:0] w_lat;
        logic [GH_OFS_W-1:0] w_lng;
        logic                ok;
    } gh_coord_t;

    // One output beat as held in a cell
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       ok;
    } gh_beat_t;

    // ASCII code of one 5-bit geohash digit
    function automatic logic [6:0] gh_char(input logic [4:0] code);
        logic [7:0] pos;
        pos = {~code, 3'b000};
        return GH_ALPHABET[pos +: 7];
    endfunction

endpackage

@@ src/geohash_encoder.sv @@
// Geohash encoder: one lat/lng pair in, one ASCII character out per beat.
// Path: an accepted pair is held in the front register, then loaded into the
// cell row; the front register can take another pair while the row shifts.
// Each pair gives N characters, N = effective precision (12 by default), one
// for an out-of-range pair; the row shifts one character per unstalled cycle.
// Reset (async, active low): all valid flags clear, prec_reg = 12.
module geohash_encoder
    import gh_pkg::*;
#(
    parameter int MAX_CHARS = 20
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [4:0]                   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [GH_COORD_W-1:0] latitude,
    input  logic signed [GH_COORD_W-1:0] longitude,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [6:0]                   hash_char,
    output logic                         is_last,
    output logic                         in_range
);

    localparam logic [4:0] MAX_C = 5'(MAX_CHARS);
    localparam logic [4:0] FALLBACK =
        (GH_FALLBACK_CHARS < MAX_C) ? GH_FALLBACK_CHARS : MAX_C;

    logic       [4:0] prec_reg;
    logic       [4:0] nchars;
    logic             front_v;
    gh_coord_t        front_d;
    logic             take;
    logic             out_fire;
    logic             cell_v [MAX_CHARS+1];
    gh_beat_t         cell_d [MAX_CHARS+1];

    // Precision register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= GH_FALLBACK_CHARS;
        end
        else if (cfg_wr_en)
        begin
            prec_reg <= cfg_wr_data;
        end
    end

    assign nchars = (prec_reg >= 5'd1 && prec_reg <= MAX_C) ? prec_reg : FALLBACK;

    gh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .latitude  (latitude),
        .longitude (longitude),
        .take      (take),
        .front_v   (front_v),
        .front_d   (front_d)
    );

    // Row refills when it is empty or its last character leaves now
    assign out_fire = out_valid && !out_stall;
    assign take     = front_v && !cell_v[1] && (!cell_v[0] || out_fire);

    // Empty slot behind the last cell
    assign cell_v[MAX_CHARS] = 1'b0;
    assign cell_d[MAX_CHARS] = '0;

    // Character cells; cell 0 drives the output
    for (genvar k = 0; k < MAX_CHARS; k++)
    begin : g_cell
        logic [4:0] code;
        logic       ld_v;
        logic       ld_last;

        // Bisection bit i comes from bit 52 - i/2; longitude on even i
        for (genvar j = 0; j < 5; j++)
        begin : g_bit
            localparam int I = 5 * k + j;
            if (I % 2 == 0)
            begin : g_lng
                assign code[4-j] = front_d.w_lng[GH_OFS_W - 1 - I / 2];
            end
            else
            begin : g_lat
                assign code[4-j] = front_d.w_lat[GH_OFS_W - 1 - I / 2];
            end
        end

        if (k == 0)
        begin : g_head
            assign ld_v    = 1'b1;
            assign ld_last = !front_d.ok || (nchars == 5'd1);
        end
        else
        begin : g_body
            assign ld_v    = front_d.ok && (5'(k) < nchars);
            assign ld_last = (5'(k + 1) == nchars);
        end

        gh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (take),
            .shift     (out_fire),
            .load_v    (ld_v),
            .load_code (code),
            .load_last (ld_last),
            .load_ok   (front_d.ok),
            .nb_v      (cell_v[k+1]),
            .nb_d      (cell_d[k+1]),
            .v         (cell_v[k]),
            .d         (cell_d[k])
        );
    end

    assign out_valid = cell_v[0];
    assign hash_char = cell_d[0].ch;
    assign is_last   = cell_d[0].last;
    assign in_range  = cell_d[0].ok;

endmodule

@@ src/gh_front.sv @@
module gh_front
    import gh_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [GH_COORD_W-1:0] latitude,
    input  logic signed [GH_COORD_W-1:0] longitude,
    input  logic                         take,
    output logic                         front_v,
    output gh_coord_t                    front_d
);

    logic signed [GH_SUM_W-1:0] s_lat;
    logic signed [GH_SUM_W-1:0] s_lng;
    logic                       ok_lat;
    logic                       ok_lng;
    logic                       accept;
    logic                       v_reg;
    logic                       v_next;
    gh_coord_t                  d_reg;
    gh_coord_t                  d_next;

    // Biased offsets and range check
    always_comb
    begin
        s_lat  = GH_SUM_W'(latitude) + GH_BIAS;
        s_lng  = GH_SUM_W'(longitude) + GH_BIAS;
        ok_lat = (s_lat >= -55'sd1) && (s_lat <= GH_SPAN);
        ok_lng = (s_lng >= -55'sd1) && (s_lng <= GH_SPAN);
        d_next.w_lat = s_lat[GH_SUM_W-1] ? '0 : s_lat[GH_OFS_W-1:0];
        d_next.w_lng = s_lng[GH_SUM_W-1] ? '0 : s_lng[GH_OFS_W-1:0];
        d_next.ok    = ok_lat && ok_lng;
    end

    // Input stage holds one beat until the cell row is free
    assign in_stall = v_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        v_next = v_reg;
        if (accept)
        begin
            v_next = 1'b1;
        end
        else if (take)
        begin
            v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg <= d_next;
        end
    end

    assign front_v = v_reg;
    assign front_d = d_reg;

endmodule

@@ src/gh_cell.sv @@
module gh_cell
    import gh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       shift,
    input  logic       load_v,
    input  logic [4:0] load_code,
    input  logic       load_last,
    input  logic       load_ok,
    input  logic       nb_v,
    input  gh_beat_t   nb_d,
    output logic       v,
    output gh_beat_t   d
);

    logic     v_reg;
    logic     v_next;
    gh_beat_t d_reg;
    gh_beat_t d_next;

    // Load a fresh character, or take the neighbor's on a shift
    always_comb
    begin
        v_next = v_reg;
        d_next = d_reg;
        if (load)
        begin
            v_next      = load_v;
            d_next.ch   = load_ok ? gh_char(load_code) : 7'd0;
            d_next.last = load_last;
            d_next.ok   = load_ok;
        end
        else if (shift)
        begin
            v_next = nb_v;
            d_next = nb_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign v = v_reg;
    assign d = d_reg;

endmodule

@@ src/gh_checker.sv @@
module gh_checker
    import gh_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic signed [GH_COORD_W-1:0] latitude,
    input logic signed [GH_COORD_W-1:0] longitude,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [6:0]                   hash_char,
    input logic                         is_last,
    input logic                         in_range
);

    // An invalid pair yields one beat only
    a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> is_last)
        else $error("invalid beat without last");

    // An invalid beat carries a zero character
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> hash_char == 7'd0)
        else $error("invalid beat with nonzero character");

    // A valid beat is a base-32 character
    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |->
            (hash_char >= 7'd48 && hash_char <= 7'd57) ||
            (hash_char >= 7'd98 && hash_char <= 7'd122))
        else $error("character outside alphabet");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(hash_char) && $stable(is_last) && $stable(in_range))
        else $error("stalled output beat changed");

    // A stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=>
            in_valid && $stable(latitude) && $stable(longitude))
        else $error("stalled input beat changed");

endmodule

bind geohash_encoder gh_checker u_chk (.*);

@@ dv/tb_geohash_encoder.sv @@
`timescale 1ns / 100ps

// Scoreboard: turns each accepted coordinate pair into its expected
// characters and checks every output beat against the oldest one
class hash_scoreboard;
    gh_pkg::gh_beat_t pending[$];
    int    errors;
    int    pairs;
    int    invalid_pairs;
    int    beats;
    int    max_chars;
    string digits;

    function new(int max_chars_in);
        max_chars     = max_chars_in;
        digits        = "0123456789bcdefghjkmnpqrstuvwxyz";
        errors        = 0;
        pairs         = 0;
        invalid_pairs = 0;
        beats         = 0;
    endfunction

    // Bisect both intervals, longitude first; a tie goes to the lower half
    function void note_pair(logic signed [53:0] lat, logic signed [53:0] lng,
                            logic [4:0] prec);
        longint           lat_v;
        longint           lng_v;
        longint           lat_lo;
        longint           lat_hi;
        longint           lng_lo;
        longint           lng_hi;
        longint           mid;
        longint           limit;
        int               nchars;
        bit               lng_turn;
        logic [4:0]       acc;
        byte              code;
        gh_pkg::gh_beat_t b;

        lat_v = lat;
        lng_v = lng;
        limit = longint'(1) << 52;
        pairs++;

        // Either coordinate outside the span gives one invalid beat
        if (lat_v < -limit || lat_v > limit || lng_v < -limit || lng_v > limit) begin
            b.ch   = 7'd0;
            b.last = 1'b1;
            b.ok   = 1'b0;
            pending.push_back(b);
            invalid_pairs++;
            return;
        end

        nchars = int'(prec);
        if (nchars < 1 || nchars > max_chars)
            nchars = (12 < max_chars) ? 12 : max_chars;

        lat_lo   = -limit;
        lat_hi   = limit;
        lng_lo   = -limit;
        lng_hi   = limit;
        lng_turn = 1'b1;
        acc      = 5'd0;
        for (int i = 1; i <= nchars * 5; i++) begin
            if (lng_turn) begin
                mid = lng_lo + ((lng_hi - lng_lo) >>> 1);
                acc = {acc[3:0], (lng_v > mid)};
                if (lng_v > mid)
                    lng_lo = mid;
                else
                    lng_hi = mid;
            end
            else begin
                mid = lat_lo + ((lat_hi - lat_lo) >>> 1);
                acc = {acc[3:0], (lat_v > mid)};
                if (lat_v > mid)
                    lat_lo = mid;
                else
                    lat_hi = mid;
            end
            if (i % 5 == 0) begin
                code   = digits[acc];
                b.ch   = code[6:0];
                b.last = (i == nchars * 5);
                b.ok   = 1'b1;
                pending.push_back(b);
                acc    = 5'd0;
            end
            lng_turn = !lng_turn;
        end
    endfunction

    function void check_beat(logic [6:0] ch, logic last, logic ok);
        gh_pkg::gh_beat_t exp_beat;

        beats++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected beat ch=0x%02h last=%0b ok=%0b", $time, ch, last, ok);
            errors++;
            return;
        end
        exp_beat = pending.pop_front();
        if (ch !== exp_beat.ch) begin
            $display("%0t: hash_char expected 0x%02h got 0x%02h", $time, exp_beat.ch, ch);
            errors++;
        end
        if (last !== exp_beat.last) begin
            $display("%0t: is_last expected %0b got %0b", $time, exp_beat.last, last);
            errors++;
        end
        if (ok !== exp_beat.ok) begin
            $display("%0t: in_range expected %0b got %0b", $time, exp_beat.ok, ok);
            errors++;
        end
    endfunction
endclass

module tb_geohash_encoder;
    import gh_pkg::*;

    localparam int MAX_CHARS   = 20;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 4;

    localparam longint LIM  = longint'(1) << 52;
    localparam longint HALF = longint'(1) << 51;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [4:0]                   cfg_wr_data = 5'd0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic signed [GH_COORD_W-1:0] latitude    = '0;
    logic signed [GH_COORD_W-1:0] longitude   = '0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic [6:0]                   hash_char;
    logic                         is_last;
    logic                         in_range;

    hash_scoreboard sb;
    logic [4:0]     precision_shadow = 5'd12;
    int             send_idle_pct    = 0;
    int             recv_stall_pct   = 0;
    int             hold_len         = 0;

    geohash_encoder #(.MAX_CHARS(MAX_CHARS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .latitude    (latitude),
        .longitude   (longitude),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_char   (hash_char),
        .is_last     (is_last),
        .in_range    (in_range)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: long hold-off when requested, otherwise random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                hold_len  = hold_len - 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pair(latitude, longitude, precision_shadow);
            if (out_valid && !out_stall)
                sb.check_beat(hash_char, is_last, in_range);
        end
    end

    // Watchdog: too long without any beat on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("timeout at %0t with %0d beats outstanding", $time, sb.pending.size());
        $display("tb_geohash_encoder: errors");
        $finish;
    end

    // One coordinate beat, with random idle cycles in front
    task automatic send_pair(longint lat, longint lng);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        latitude  <= lat[53:0];
        longitude <= lng[53:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every expected character
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_precision(logic [4:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        precision_shadow = value;
        @(posedge clk);
    endtask

    // Random coordinate: mostly in range, plus ties, bounds and raw bits
    function automatic longint rand_coord();
        longint unsigned r;
        longint          v;
        int unsigned     pick;
        int              sh;

        r    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 10)
            v = longint'(r);
        else if (pick < 30)
        begin
            // multiples of a power of two land on bisection midpoints
            sh = $urandom_range(52);
            v  = (longint'(r % 5) - 2) <<< sh;
        end
        else if (pick < 40)
        begin
            case (r[2:0])
                3'd0, 3'd1: v = LIM;
                3'd2, 3'd3: v = -LIM;
                3'd4:       v = (longint'(1) << 53) - 1;
                3'd5:       v = -(longint'(1) << 53);
                default:    v = 0;
            endcase
            v = v + (int'($urandom_range(6)) - 3);
        end
        else
            v = longint'(r % 64'h0020_0000_0000_0001) - LIM;
        return {{10{v[53]}}, v[53:0]};
    endfunction

    task automatic run_phase(int n, logic [4:0] prec, int snd_pct, int rcv_pct);
        write_precision(prec);
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        repeat (n) send_pair(rand_coord(), rand_coord());
    endtask

    // Main sequence
    initial
    begin
        sb = new(MAX_CHARS);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset precision
        send_pair(0, 0);                          // first step of each coordinate a tie
        send_pair(LIM, LIM);                      // upper bounds, still valid
        send_pair(-LIM, -LIM);                    // lower bounds, still valid
        send_pair(LIM, -LIM);
        send_pair(LIM + 1, 0);                    // latitude just out of range
        send_pair(0, -LIM - 1);                   // longitude just out of range
        send_pair((longint'(1) << 53) - 1, -(longint'(1) << 53));
        send_pair(-(longint'(1) << 53), (longint'(1) << 53) - 1);
        send_pair(HALF, -HALF);                   // second-level midpoints
        send_pair(1, -1);
        send_pair(LIM - 1, -LIM + 1);
        send_pair(longint'(54'h0AAAAAAAAAAAAA), -longint'(54'h05555555555555));
        send_pair(longint'(54'h02F3B1C9A4E7D5), -longint'(54'h01C2E8F0B3A961));

        // Precision corners: zero and above the maximum fall back to twelve
        write_precision(5'd0);
        send_pair(LIM, 0);
        write_precision(5'd1);
        send_pair(0, 0);
        send_pair(-1, 1);
        write_precision(5'd20);
        send_pair(0, 0);
        send_pair(LIM, -LIM);
        write_precision(5'd31);
        send_pair(1, 1);
        write_precision(5'd21);
        send_pair(-HALF, HALF);

        // Random phases
        run_phase(60, 5'd12, 0, 0);
        run_phase(60, 5'd20, 59, 0);
        run_phase(60, 5'd1, 0, 59);
        run_phase(60, 5'd0, 37, 37);

        // Back-pressure: receiver holds off while the sender keeps offering
        write_precision(5'd20);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 400;
        repeat (40) send_pair(rand_coord(), rand_coord());
        // sender pauses until the block is empty, then resumes
        drain_results();
        repeat (20) send_pair(rand_coord(), rand_coord());

        run_phase(50, 5'd3, 59, 0);
        run_phase(50, 5'd21, 0, 59);
        run_phase(50, 5'd17, 37, 37);

        drain_results();
        repeat (10) @(posedge clk);

        $display("summary: %0d coordinate pairs (%0d out of range), %0d characters checked",
                 sb.pairs, sb.invalid_pairs, sb.beats);
        $display("precisions 12 0 1 20 31 21 3 17, with sender gaps, receiver stalls and a long hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_geohash_encoder: clean");
        else
        begin
            $display("%0d mismatches, %0d beats never arrived", sb.errors, sb.pending.size());
            $display("tb_geohash_encoder: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/gh_pkg.sv
src/gh_front.sv
src/gh_cell.sv
src/geohash_encoder.sv
src/gh_checker.sv
dv/tb_geohash_encoder.sv
